[rtl/core/utd_pkg.sv]
// utd_pkg: shared types, constants and the glyph map of the utf-8 glyph decoder
// used by utd_front, utd_fifo, utd_back and utf8_to_glyph_decoder
package utd_pkg;

  localparam int unsigned CP_W = 21;

  // lead and continuation byte classes
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_VAL  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_VAL  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_VAL  = 8'hF0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_VAL   = 8'h80;

  // symbol code points and their glyph slots
  localparam logic [CP_W-1:0] CP_ARROW_LEFT  = 21'h02190;
  localparam logic [CP_W-1:0] CP_ARROW_UP    = 21'h02191;
  localparam logic [CP_W-1:0] CP_ARROW_RIGHT = 21'h02192;
  localparam logic [CP_W-1:0] CP_ARROW_DOWN  = 21'h02193;
  localparam logic [CP_W-1:0] CP_SHIFT_KEY   = 21'h021E7;
  localparam logic [CP_W-1:0] CP_RETURN_KEY  = 21'h023CE;

  localparam logic [6:0] GL_ARROW_LEFT  = 7'd16;
  localparam logic [6:0] GL_ARROW_UP    = 7'd17;
  localparam logic [6:0] GL_ARROW_RIGHT = 7'd18;
  localparam logic [6:0] GL_ARROW_DOWN  = 7'd19;
  localparam logic [6:0] GL_SHIFT_KEY   = 7'd20;
  localparam logic [6:0] GL_RETURN_KEY  = 7'd21;
  localparam logic [6:0] GL_NONE        = 7'd0;

  localparam logic [7:0] MAX_GLYPHS_RST = 8'd128;

  // kind of work handed from front to back
  typedef enum logic [1:0] {
    REC_GLYPH,
    REC_END,
    REC_GLYPH_END
  } rec_kind_t;

  typedef struct packed {
    rec_kind_t  kind;
    logic [6:0] glyph;
    logic [7:0] count;
    logic       err;
  } rec_t;

  typedef enum logic {
    BK_HEAD,
    BK_TAIL
  } back_state_t;

  // code point to font glyph index
  function automatic logic [6:0] map_glyph(input logic [CP_W-1:0] cp);
    logic [6:0] g;
    g = GL_NONE;
    if (cp >= 21'h20 && cp < 21'h80) begin
      g = cp[6:0];
    end else begin
      case (cp)
        CP_ARROW_LEFT:  g = GL_ARROW_LEFT;
        CP_ARROW_UP:    g = GL_ARROW_UP;
        CP_ARROW_RIGHT: g = GL_ARROW_RIGHT;
        CP_ARROW_DOWN:  g = GL_ARROW_DOWN;
        CP_SHIFT_KEY:   g = GL_SHIFT_KEY;
        CP_RETURN_KEY:  g = GL_RETURN_KEY;
        default:        g = GL_NONE;
      endcase
    end
    return g;
  endfunction

endpackage

[rtl/core/utd_front.sv]
// utd_front: byte classifier and sequence assembler of the utf-8 glyph decoder
// depends on utd_pkg; emits one work record per byte that causes results
module utd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_take,
  input  logic [7:0]        byte_data,
  input  logic [7:0]        max_glyphs,
  output logic              rec_valid,
  output utd_pkg::rec_t     rec
);
  import utd_pkg::*;

  logic [1:0]      pend_r,  pend_nxt;
  logic [CP_W-1:0] cp_r,    cp_nxt;
  logic [7:0]      count_r, count_nxt;
  logic            drop_r,  drop_nxt;

  logic            glyph_done;
  logic [CP_W-1:0] cp_done;
  logic [1:0]      pend_dec;
  logic [7:0]      count_inc;
  logic [7:0]      limit;

  assign pend_dec  = pend_r - 2'd1;
  assign count_inc = count_r + 8'd1;
  assign limit     = (max_glyphs == 8'd0) ? 8'd1 : max_glyphs;

  // per-byte decode step
  always_comb begin
    pend_nxt   = pend_r;
    cp_nxt     = cp_r;
    count_nxt  = count_r;
    drop_nxt   = drop_r;
    rec_valid  = 1'b0;
    rec.kind   = REC_END;
    rec.glyph  = GL_NONE;
    rec.count  = count_r;
    rec.err    = 1'b0;
    glyph_done = 1'b0;
    cp_done    = '0;

    if (byte_take) begin
      if (drop_r) begin
        // skip to the terminator
        if (byte_data == 8'd0) begin
          drop_nxt  = 1'b0;
          count_nxt = 8'd0;
          pend_nxt  = 2'd0;
          cp_nxt    = '0;
        end
      end else if (pend_r != 2'd0) begin
        // continuation expected
        if (byte_data == 8'd0 || (byte_data & CONT_MASK) != CONT_VAL) begin
          rec_valid = 1'b1;
          rec.err   = 1'b1;
          count_nxt = 8'd0;
          pend_nxt  = 2'd0;
          cp_nxt    = '0;
          drop_nxt  = (byte_data != 8'd0);
        end else begin
          pend_nxt = pend_dec;
          case (pend_dec)
            2'd0:    cp_done = cp_r | {15'd0, byte_data[5:0]};
            2'd1:    cp_done = cp_r | {9'd0, byte_data[5:0], 6'd0};
            2'd2:    cp_done = cp_r | {3'd0, byte_data[5:0], 12'd0};
            default: cp_done = cp_r;
          endcase
          cp_nxt     = cp_done;
          glyph_done = (pend_dec == 2'd0);
        end
      end else if (byte_data == 8'd0) begin
        // clean terminator
        rec_valid = 1'b1;
        count_nxt = 8'd0;
        cp_nxt    = '0;
      end else if (!byte_data[7]) begin
        cp_done    = {13'd0, byte_data};
        glyph_done = 1'b1;
      end else if ((byte_data & LEAD2_MASK) == LEAD2_VAL) begin
        cp_nxt   = {10'd0, byte_data[4:0], 6'd0};
        pend_nxt = 2'd1;
      end else if ((byte_data & LEAD3_MASK) == LEAD3_VAL) begin
        cp_nxt   = {5'd0, byte_data[3:0], 12'd0};
        pend_nxt = 2'd2;
      end else if ((byte_data & LEAD4_MASK) == LEAD4_VAL) begin
        cp_nxt   = {byte_data[2:0], 18'd0};
        pend_nxt = 2'd3;
      end else begin
        // bad lead byte
        rec_valid = 1'b1;
        rec.err   = 1'b1;
        count_nxt = 8'd0;
        cp_nxt    = '0;
        drop_nxt  = 1'b1;
      end

      // finished code point: glyph, and end of string at the limit
      if (glyph_done) begin
        rec_valid = 1'b1;
        rec.glyph = map_glyph(cp_done);
        rec.count = count_inc;
        cp_nxt    = '0;
        if (count_inc >= limit) begin
          rec.kind  = REC_GLYPH_END;
          count_nxt = 8'd0;
          pend_nxt  = 2'd0;
          drop_nxt  = 1'b1;
        end else begin
          rec.kind  = REC_GLYPH;
          count_nxt = count_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 2'd0;
      cp_r    <= '0;
      count_r <= 8'd0;
      drop_r  <= 1'b0;
    end else begin
      pend_r  <= pend_nxt;
      cp_r    <= cp_nxt;
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
    end
  end

endmodule

[rtl/core/utd_fifo.sv]
// utd_fifo: short record queue between decoder front and result back end
// depends on utd_pkg for the record type
module utd_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  utd_pkg::rec_t push_rec,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output utd_pkg::rec_t head_rec
);
  import utd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  rec_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r,    cnt_nxt;
  logic             do_push, do_pop;

  assign full       = (cnt_r == CNT_FULL);
  assign head_valid = (cnt_r != '0);
  assign head_rec   = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // record storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

[rtl/core/utd_back.sv]
// utd_back: turns queued records into result transfers through an output register
// depends on utd_pkg; a glyph-plus-end record leaves as two transfers
module utd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  utd_pkg::rec_t head_rec,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [6:0]    out_glyph,
  output logic          out_is_end,
  output logic          out_had_error,
  output logic [7:0]    out_glyph_count,
  output logic          out_last
);
  import utd_pkg::*;

  back_state_t state_r, state_nxt;
  logic        valid_r;
  logic [6:0]  glyph_r;
  logic        is_end_r;
  logic        err_r;
  logic [7:0]  count_r;
  logic        last_r;
  logic [7:0]  tail_cnt_r;

  logic        load;
  logic        res_valid;
  logic [6:0]  res_glyph;
  logic        res_is_end;
  logic        res_err;
  logic [7:0]  res_count;
  logic        res_last;

  assign load = !valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_HEAD: begin
        if (load && head_valid && head_rec.kind == REC_GLYPH_END) begin
          state_nxt = BK_TAIL;
        end
      end
      BK_TAIL: begin
        if (load) begin
          state_nxt = BK_HEAD;
        end
      end
      default: state_nxt = BK_HEAD;
    endcase
  end

  // result selection and queue pop
  always_comb begin
    pop        = 1'b0;
    res_valid  = 1'b0;
    res_glyph  = GL_NONE;
    res_is_end = 1'b1;
    res_err    = 1'b0;
    res_count  = tail_cnt_r;
    res_last   = 1'b1;
    case (state_r)
      BK_HEAD: begin
        pop       = load && head_valid;
        res_valid = head_valid;
        res_count = head_rec.count;
        case (head_rec.kind)
          REC_GLYPH: begin
            res_glyph  = head_rec.glyph;
            res_is_end = 1'b0;
          end
          REC_GLYPH_END: begin
            res_glyph  = head_rec.glyph;
            res_is_end = 1'b0;
            res_last   = 1'b0;
          end
          default: begin
            res_err = head_rec.err;
          end
        endcase
      end
      BK_TAIL: begin
        res_valid = 1'b1;
      end
      default: res_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_HEAD;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        valid_r <= res_valid;
      end
    end
  end

  // output register and held end count
  always_ff @(posedge clk) begin
    if (load) begin
      glyph_r  <= res_glyph;
      is_end_r <= res_is_end;
      err_r    <= res_err;
      count_r  <= res_count;
      last_r   <= res_last;
    end
    if (pop) begin
      tail_cnt_r <= head_rec.count;
    end
  end

  assign out_valid       = valid_r;
  assign out_glyph       = glyph_r;
  assign out_is_end      = is_end_r;
  assign out_had_error   = err_r;
  assign out_glyph_count = count_r;
  assign out_last        = last_r;

endmodule

[rtl/core/utf8_to_glyph_decoder.sv]
// utf8_to_glyph_decoder: top level of the utf-8 string to font glyph decoder
// depends on utd_pkg, utd_front, utd_fifo and utd_back
//
//   channel   direction  handshake            payload
//   in_       input      in_valid / in_stall   in_data_byte
//   out_      output     out_valid / out_stall out_glyph, out_is_end, out_had_error,
//                                              out_glyph_count, out_last
//   cfg_      input      cfg_we                cfg_wdata (max_glyphs)
//
// one byte is taken per clock while the queue is not full; the front decodes it
// in the cycle of its transfer; a byte's first result is written into the record queue
// and then loaded into the output register, which drives the out_ channel
// a byte that hits the glyph limit gives two results, a glyph and then an end
// in_stall rises only when the FIFO_DEPTH-entry record queue is full
// rst_n is synchronous; it clears decode state, queue and output valid, max_glyphs to 128
module utf8_to_glyph_decoder #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_glyph,
  output logic       out_is_end,
  output logic       out_had_error,
  output logic [7:0] out_glyph_count,
  output logic       out_last,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import utd_pkg::*;

  logic [7:0] max_glyphs_r;
  logic       byte_take;
  logic       rec_valid;
  rec_t       rec;
  logic       q_full;
  logic       head_valid;
  rec_t       head_rec;
  logic       pop;

  // glyph limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_glyphs_r <= MAX_GLYPHS_RST;
    end else if (cfg_we) begin
      max_glyphs_r <= cfg_wdata;
    end
  end

  assign in_stall  = q_full;
  assign byte_take = in_valid && !q_full;

  utd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_take  (byte_take),
    .byte_data  (in_data_byte),
    .max_glyphs (max_glyphs_r),
    .rec_valid  (rec_valid),
    .rec        (rec)
  );

  utd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (rec_valid),
    .push_rec   (rec),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_rec   (head_rec)
  );

  utd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_rec        (head_rec),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_glyph       (out_glyph),
    .out_is_end      (out_is_end),
    .out_had_error   (out_had_error),
    .out_glyph_count (out_glyph_count),
    .out_last        (out_last)
  );

endmodule

[verif/tb_utf8_to_glyph_decoder.sv]
// tb_utf8_to_glyph_decoder: self-checking testbench for the utf-8 to font glyph decoder
// drives byte strings through utf8_to_glyph_decoder and checks every result against
// a built-in decode model or the typed rows; needs every file under rtl/core
module tb_utf8_to_glyph_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASES        = 8;
  localparam int PHASE_BYTES   = 55;

  // symbol code points with their own glyph slots
  localparam logic [20:0] CP_LEFT   = 21'h02190;
  localparam logic [20:0] CP_UP     = 21'h02191;
  localparam logic [20:0] CP_RIGHT  = 21'h02192;
  localparam logic [20:0] CP_DOWN   = 21'h02193;
  localparam logic [20:0] CP_SHIFT  = 21'h021E7;
  localparam logic [20:0] CP_RETURN = 21'h023CE;

  typedef struct packed {
    logic [6:0] glyph;
    logic       is_end;
    logic       had_error;
    logic [7:0] count;
    logic       last;
  } glyph_res_t;

  localparam glyph_res_t NO_RESULT = '0;

  typedef enum logic {
    ROW_BYTE,
    ROW_CFG
  } row_kind_t;

  // one offered byte or limit write, with hand-written expectations where typed is set
  typedef struct {
    row_kind_t  kind;
    logic [7:0] value;
    bit         typed;
    int         n;
    glyph_res_t r0;
    glyph_res_t r1;
  } stim_row_t;

  // ways a malformed string is built
  typedef enum logic [1:0] {
    FLAW_CUT,
    FLAW_BAD_CONT,
    FLAW_BAD_LEAD,
    FLAW_NOISE
  } flaw_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [6:0] out_glyph;
  logic       out_is_end;
  logic       out_had_error;
  logic [7:0] out_glyph_count;
  logic       out_last;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  // decode model state
  logic [1:0]  dec_pending = '0;
  logic [20:0] dec_cp = '0;
  logic [7:0]  dec_count = '0;
  logic        dec_dropping = 1'b0;
  logic [7:0]  dec_limit = 8'd128;

  glyph_res_t pending_results[$];
  stim_row_t  offered_bytes[$];
  stim_row_t  directed_rows[31];
  int         mismatches = 0;
  int         decoded_bytes = 0;
  int         in_idle_pct = 0;
  int         out_stall_pct = 0;
  int         hold_requests = 0;
  int         hold_served = 0;
  int         hold_left = 0;
  int         quiet_cycles = 0;

  utf8_to_glyph_decoder u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_glyph       (out_glyph),
    .out_is_end      (out_is_end),
    .out_had_error   (out_had_error),
    .out_glyph_count (out_glyph_count),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // result builders
  function automatic glyph_res_t glyph_res(input logic [6:0] g, input logic [7:0] cnt,
                                           input logic lst);
    glyph_res_t r;
    r = '0;
    r.glyph = g;
    r.count = cnt;
    r.last  = lst;
    return r;
  endfunction

  function automatic glyph_res_t end_res(input logic err, input logic [7:0] cnt);
    glyph_res_t r;
    r = '0;
    r.is_end    = 1'b1;
    r.had_error = err;
    r.count     = cnt;
    r.last      = 1'b1;
    return r;
  endfunction

  // stimulus table rows
  function automatic stim_row_t byte_row(input logic [7:0] b, input int n,
                                         input glyph_res_t r0, input glyph_res_t r1);
    stim_row_t row;
    row.kind  = ROW_BYTE;
    row.value = b;
    row.typed = 1'b1;
    row.n     = n;
    row.r0    = r0;
    row.r1    = r1;
    return row;
  endfunction

  function automatic stim_row_t free_row(input logic [7:0] b);
    stim_row_t row;
    row = byte_row(b, 0, NO_RESULT, NO_RESULT);
    row.typed = 1'b0;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input logic [7:0] v);
    stim_row_t row;
    row = free_row(v);
    row.kind = ROW_CFG;
    return row;
  endfunction

  // code point to glyph slot
  function automatic logic [6:0] glyph_of(input logic [20:0] cp);
    if (cp >= 21'h20 && cp < 21'h80) begin
      return cp[6:0];
    end
    case (cp)
      CP_LEFT:   return 7'd16;
      CP_UP:     return 7'd17;
      CP_RIGHT:  return 7'd18;
      CP_DOWN:   return 7'd19;
      CP_SHIFT:  return 7'd20;
      CP_RETURN: return 7'd21;
      default:   return 7'd0;
    endcase
  endfunction

  // end the current string and clear the decode state
  function automatic glyph_res_t close_string(input logic err, input logic drop);
    glyph_res_t r;
    r = end_res(err, dec_count);
    dec_count    = '0;
    dec_pending  = '0;
    dec_cp       = '0;
    dec_dropping = drop;
    return r;
  endfunction

  // finished code point; reaching the limit adds an end result
  function automatic int emit_glyph(output glyph_res_t r0, output glyph_res_t r1);
    logic [6:0] g;
    logic [7:0] lim;
    g = glyph_of(dec_cp);
    lim = (dec_limit == 8'd0) ? 8'd1 : dec_limit;
    dec_count = dec_count + 8'd1;
    dec_cp = '0;
    r1 = NO_RESULT;
    if (dec_count >= lim) begin
      r0 = glyph_res(g, dec_count, 1'b0);
      r1 = close_string(1'b0, 1'b1);
      return 2;
    end
    r0 = glyph_res(g, dec_count, 1'b1);
    return 1;
  endfunction

  // decode one byte, returns the number of results it causes
  function automatic int decode_byte(input logic [7:0] b, output glyph_res_t r0,
                                     output glyph_res_t r1);
    r0 = NO_RESULT;
    r1 = NO_RESULT;
    if (dec_dropping) begin
      if (b == 8'h00) begin
        dec_dropping = 1'b0;
        dec_count    = '0;
        dec_pending  = '0;
        dec_cp       = '0;
      end
      return 0;
    end
    if (dec_pending != 2'd0) begin
      if (b == 8'h00) begin
        r0 = close_string(1'b1, 1'b0);
        return 1;
      end
      if ((b & 8'hC0) != 8'h80) begin
        r0 = close_string(1'b1, 1'b1);
        return 1;
      end
      dec_pending = dec_pending - 2'd1;
      dec_cp = dec_cp | (21'(b[5:0]) << (dec_pending * 6));
      if (dec_pending == 2'd0) begin
        return emit_glyph(r0, r1);
      end
      return 0;
    end
    if (b == 8'h00) begin
      r0 = close_string(1'b0, 1'b0);
      return 1;
    end
    if (b < 8'h80) begin
      dec_cp = 21'(b);
      return emit_glyph(r0, r1);
    end
    if ((b & 8'hE0) == 8'hC0) begin
      dec_cp = 21'(b[4:0]) << 6;
      dec_pending = 2'd1;
    end else if ((b & 8'hF0) == 8'hE0) begin
      dec_cp = 21'(b[3:0]) << 12;
      dec_pending = 2'd2;
    end else if ((b & 8'hF8) == 8'hF0) begin
      dec_cp = 21'(b[2:0]) << 18;
      dec_pending = 2'd3;
    end else begin
      r0 = close_string(1'b1, 1'b1);
      return 1;
    end
    return 0;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // offer one byte, with random idle cycles ahead of it, and wait for its transfer
  task automatic offer_byte(input stim_row_t row);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= row.value;
    offered_bytes.push_back(row);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_raw(input logic [7:0] b);
    offer_byte(free_row(b));
  endtask

  // utf-8 encoding of a code point in len bytes
  task automatic send_cp(input logic [20:0] cp, input int len);
    case (len)
      1: begin
        send_raw(cp[7:0]);
      end
      2: begin
        send_raw({3'b110, cp[10:6]});
        send_raw({2'b10, cp[5:0]});
      end
      3: begin
        send_raw({4'b1110, cp[15:12]});
        send_raw({2'b10, cp[11:6]});
        send_raw({2'b10, cp[5:0]});
      end
      default: begin
        send_raw({5'b11110, cp[20:18]});
        send_raw({2'b10, cp[17:12]});
        send_raw({2'b10, cp[11:6]});
        send_raw({2'b10, cp[5:0]});
      end
    endcase
  endtask

  task automatic send_char();
    logic [20:0] cp;
    case ($urandom_range(6))
      0, 1: begin
        send_cp(21'($urandom_range('h20, 'h7F)), 1);
      end
      2: begin
        send_cp(21'($urandom_range(1, 'h1F)), 1);
      end
      3: begin
        send_cp(21'($urandom_range(0, 'h7FF)), 2);
      end
      4: begin
        case ($urandom_range(5))
          0:       cp = CP_LEFT;
          1:       cp = CP_UP;
          2:       cp = CP_RIGHT;
          3:       cp = CP_DOWN;
          4:       cp = CP_SHIFT;
          default: cp = CP_RETURN;
        endcase
        send_cp(cp, 3);
      end
      5: begin
        send_cp(21'($urandom_range(0, 'hFFFF)), 3);
      end
      default: begin
        send_cp(21'($urandom), 4);
      end
    endcase
  endtask

  task automatic send_text(input int nchar);
    repeat (nchar) send_char();
    send_raw(8'h00);
  endtask

  // mostly well-formed strings, the rest broken in one of several ways
  task automatic send_string();
    flaw_t      flaw;
    int         lead_len;
    logic [7:0] lead;
    logic [7:0] bad;
    if ($urandom_range(99) < 75) begin
      send_text($urandom_range(0, 12));
    end else begin
      repeat ($urandom_range(0, 4)) send_char();
      flaw = flaw_t'($urandom_range(3));
      lead_len = $urandom_range(2, 4);
      lead = (lead_len == 2) ? {3'b110, 5'($urandom)} :
             (lead_len == 3) ? {4'b1110, 4'($urandom)} : {5'b11110, 3'($urandom)};
      // partial sequence
      if (flaw == FLAW_CUT || flaw == FLAW_BAD_CONT) begin
        send_raw(lead);
        repeat ($urandom_range(0, lead_len - 2)) send_raw({2'b10, 6'($urandom)});
      end
      if (flaw == FLAW_BAD_CONT) begin
        do bad = 8'($urandom_range(1, 255)); while (bad[7:6] == 2'b10);
        send_raw(bad);
      end
      if (flaw == FLAW_BAD_LEAD) begin
        send_raw($urandom_range(1) ? 8'($urandom_range('h80, 'hBF)) :
                                     8'($urandom_range('hF8, 'hFF)));
      end
      if (flaw == FLAW_NOISE) begin
        repeat ($urandom_range(1, 10)) send_raw(8'($urandom_range(1, 255)));
      end
      // tail after the defect, dropped up to the terminator
      if (flaw != FLAW_CUT) begin
        repeat ($urandom_range(0, 6)) send_raw(8'($urandom_range(0, 255)));
      end
      send_raw(8'h00);
    end
  endtask

  // stop offering and let every expected result come out
  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    dec_limit = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver stalls, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  // predict on each input transfer, check each output transfer
  always @(posedge clk) begin : monitor
    stim_row_t  row;
    glyph_res_t r0;
    glyph_res_t r1;
    glyph_res_t want;
    int         n;
    if (rst_n && in_valid && !in_stall) begin
      row = offered_bytes.pop_front();
      n = decode_byte(in_data_byte, r0, r1);
      decoded_bytes++;
      if (row.typed) begin
        n  = row.n;
        r0 = row.r0;
        r1 = row.r1;
      end
      if (n > 0) begin
        pending_results.push_back(r0);
      end
      if (n > 1) begin
        pending_results.push_back(r1);
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: glyph %0d is_end %0b count %0d",
               out_glyph, out_is_end, out_glyph_count);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("glyph", 8'(want.glyph), 8'(out_glyph));
        check_field("is_end", 8'(want.is_end), 8'(out_is_end));
        check_field("had_error", 8'(want.had_error), 8'(out_had_error));
        check_field("glyph_count", want.count, out_glyph_count);
        check_field("last", 8'(want.last), 8'(out_last));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL utf8_to_glyph_decoder");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int         ph;
    int         phase_start;
    logic [7:0] lim;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed strings, starting from the reset limit of 128
    directed_rows = '{
      byte_row(8'h41, 1, glyph_res(7'h41, 8'd1, 1'b1), NO_RESULT),
      byte_row(8'h7F, 1, glyph_res(7'h7F, 8'd2, 1'b1), NO_RESULT),
      // control character still counts as a glyph
      byte_row(8'h01, 1, glyph_res(7'd0, 8'd3, 1'b1), NO_RESULT),
      // left arrow
      byte_row(8'hE2, 0, NO_RESULT, NO_RESULT),
      byte_row(8'h86, 0, NO_RESULT, NO_RESULT),
      byte_row(8'h90, 1, glyph_res(7'd16, 8'd4, 1'b1), NO_RESULT),
      // shift key, return key, highest four-byte code point
      free_row(8'hE2), free_row(8'h87), free_row(8'hA7),
      free_row(8'hE2), free_row(8'h8F), free_row(8'h8E),
      free_row(8'hF4), free_row(8'h8F), free_row(8'hBF), free_row(8'hBF),
      byte_row(8'h00, 1, end_res(1'b0, 8'd7), NO_RESULT),
      // bad lead byte, then dropped up to the terminator
      byte_row(8'hFF, 1, end_res(1'b1, 8'd0), NO_RESULT),
      byte_row(8'h41, 0, NO_RESULT, NO_RESULT),
      byte_row(8'h00, 0, NO_RESULT, NO_RESULT),
      // terminator inside a sequence
      byte_row(8'hC2, 0, NO_RESULT, NO_RESULT),
      byte_row(8'h00, 1, end_res(1'b1, 8'd0), NO_RESULT),
      // bad continuation byte
      free_row(8'hE2),
      byte_row(8'h41, 1, end_res(1'b1, 8'd0), NO_RESULT),
      byte_row(8'h00, 0, NO_RESULT, NO_RESULT),
      // limit of one glyph: glyph and end from one byte
      cfg_row(8'd1),
      byte_row(8'h41, 2, glyph_res(7'h41, 8'd1, 1'b0), end_res(1'b0, 8'd1)),
      byte_row(8'h00, 0, NO_RESULT, NO_RESULT),
      // continuation byte as a lead
      cfg_row(8'd255),
      byte_row(8'h80, 1, end_res(1'b1, 8'd0), NO_RESULT),
      byte_row(8'h00, 0, NO_RESULT, NO_RESULT)
    };
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_limit(directed_rows[i].value);
      end else begin
        offer_byte(directed_rows[i]);
      end
    end

    // random strings over several limits and idle patterns
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       lim = 8'd2;
        1:       lim = 8'd255;
        2:       lim = 8'd1;
        3:       lim = 8'd0;
        4:       lim = 8'($urandom_range(2, 16));
        5:       lim = 8'd128;
        6:       lim = 8'd3;
        default: lim = 8'($urandom_range(0, 255));
      endcase
      write_limit(lim);
      case (ph / 2)
        0: begin
          in_idle_pct = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_idle_pct = 80;
          out_stall_pct = 0;
        end
        2: begin
          in_idle_pct = 0;
          out_stall_pct = 80;
        end
        default: begin
          in_idle_pct = 31;
          out_stall_pct = 31;
        end
      endcase
      // long hold-off under a long string: fills the block, reaches the 255 limit
      if (ph == 1) begin
        hold_requests++;
        send_text(260);
      end
      phase_start = decoded_bytes;
      while (decoded_bytes - phase_start < PHASE_BYTES) send_string();
    end

    drain();
    if (mismatches == 0) begin
      $display("PASS utf8_to_glyph_decoder");
    end else begin
      $display("FAIL utf8_to_glyph_decoder");
    end
    $finish;
  end

endmodule
